@@ hw/rtl/qau_pkg.sv @@
// Quaternion arithmetic unit: shared types, codes and fixed-point helpers.
// No dependencies; used by every module of the block.
package qau_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * DATA_W + 2;   // product of a word and a 33-bit word
  localparam int ACC_W       = 2 * DATA_W + 4;   // sum of four products
  localparam int SQ_W        = 2 * DATA_W + 1;   // sum of four squares
  localparam int SQRT_STAGES = DATA_W;
  localparam int DIV_STAGES  = DATA_W + 1;
  localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [2:0] CMD_MUL   = 3'd0;
  localparam logic [2:0] CMD_SCALE = 3'd1;
  localparam logic [2:0] CMD_CONJ  = 3'd2;
  localparam logic [2:0] CMD_DOT   = 3'd3;
  localparam logic [2:0] CMD_ROT   = 3'd4;
  localparam logic [2:0] CMD_NORM  = 3'd5;
  localparam logic [2:0] CMD_INV   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_INV = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef enum logic [2:0] {
    OP_MUL, OP_SCALE, OP_CONJ, OP_DOT, OP_ROT, OP_NORM, OP_INV, OP_NONE
  } op_t;

  typedef logic [DATA_W-1:0]     word_t;
  typedef word_t [3:0]           quad_t;    // index 0 is w
  typedef logic [PROD_W-1:0]     prod_t;
  typedef prod_t [3:0][3:0]      pmat_t;
  typedef logic [2*DATA_W-1:0]   dword_t;
  typedef logic [DIV_STAGES-1:0] quo_t;

  typedef struct packed {
    op_t   op;
    quad_t a;
    quad_t y;    // second multiplier operand
    word_t b0;
  } entry_t;

  typedef struct packed {
    logic  ov;
    word_t v;
  } sat_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t ONE_Q    = word_t'(64'd1 << FRAC_W);

  // Terms of the Hamilton product that are subtracted, per component.
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  function automatic logic signed [ACC_W-1:0] ext_prod(input prod_t p);
    return $signed({{(ACC_W-PROD_W){p[PROD_W-1]}}, p});
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_word(input word_t w);
    return $signed({{(ACC_W-DATA_W){w[DATA_W-1]}}, w});
  endfunction

  // component "row" of the product sum: term i pairs x_i with y_(i^row)
  function automatic logic signed [ACC_W-1:0] ham_sum(input pmat_t p, input logic [1:0] row,
                                                      input logic [3:0] neg);
    logic signed [ACC_W-1:0] acc;
    logic [1:0] col;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      col = 2'(i) ^ row;
      if (neg[i]) acc = acc - ext_prod(p[i][col]);
      else acc = acc + ext_prod(p[i][col]);
    end
    return acc;
  endfunction

  function automatic logic signed [ACC_W-1:0] floor_q(input logic signed [ACC_W-1:0] v);
    return v >>> FRAC_W;
  endfunction

  function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
    sat_t r;
    r.ov = !((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]));
    r.v  = r.ov ? (v[ACC_W-1] ? WORD_MIN : WORD_MAX) : v[DATA_W-1:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/qau_front.sv @@
// Front end: decodes the command and selects multiplier operands.
// Depends on qau_pkg.
module qau_front (
  input  logic             in_valid,
  input  logic             fifo_full,
  input  logic [2:0]       in_command,
  input  qau_pkg::word_t   in_a_w,
  input  qau_pkg::word_t   in_a_x,
  input  qau_pkg::word_t   in_a_y,
  input  qau_pkg::word_t   in_a_z,
  input  qau_pkg::word_t   in_b_w,
  input  qau_pkg::word_t   in_b_x,
  input  qau_pkg::word_t   in_b_y,
  input  qau_pkg::word_t   in_b_z,
  output logic             in_stall,
  output logic             push,
  output qau_pkg::entry_t  entry
);

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    entry.a  = {in_a_z, in_a_y, in_a_x, in_a_w};
    entry.b0 = in_b_w;
    unique case (in_command)
      qau_pkg::CMD_MUL:   entry.op = qau_pkg::OP_MUL;
      qau_pkg::CMD_SCALE: entry.op = qau_pkg::OP_SCALE;
      qau_pkg::CMD_CONJ:  entry.op = qau_pkg::OP_CONJ;
      qau_pkg::CMD_DOT:   entry.op = qau_pkg::OP_DOT;
      qau_pkg::CMD_ROT:   entry.op = qau_pkg::OP_ROT;
      qau_pkg::CMD_NORM:  entry.op = qau_pkg::OP_NORM;
      qau_pkg::CMD_INV:   entry.op = qau_pkg::OP_INV;
      default:            entry.op = qau_pkg::OP_NONE;
    endcase
    // squares for the length, a pure vector for rotation
    unique case (entry.op)
      qau_pkg::OP_NORM, qau_pkg::OP_INV: entry.y = entry.a;
      qau_pkg::OP_ROT: entry.y = {in_b_z, in_b_y, in_b_x, qau_pkg::word_t'(0)};
      default:         entry.y = {in_b_z, in_b_y, in_b_x, in_b_w};
    endcase
  end

endmodule

@@ hw/rtl/qau_fifo.sv @@
// Decoupling queue between front and back end.
// Depends on qau_pkg (entry_t, depth constants).
module qau_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qau_pkg::entry_t  push_data,
  input  logic             pop,
  output qau_pkg::entry_t  head,
  output logic             full,
  output logic             empty
);

  qau_pkg::entry_t mem_r [qau_pkg::FIFO_DEPTH];
  logic [qau_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [qau_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + qau_pkg::FIFO_CW'(push) - qau_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = cnt_r == qau_pkg::FIFO_CW'(qau_pkg::FIFO_DEPTH);
  assign empty = cnt_r == '0;

endmodule

@@ hw/rtl/qau_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on qau_pkg.
module qau_sqrt (
  input  logic            clk,
  input  logic            en,
  input  qau_pkg::dword_t s_in,
  output qau_pkg::word_t  root
);

  qau_pkg::dword_t n_r   [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t q_r   [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t n_in  [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t q_in  [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t n_nxt [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t q_nxt [qau_pkg::SQRT_STAGES];
  qau_pkg::dword_t trial, bitc;

  always_comb begin
    n_in[0] = s_in;
    q_in[0] = '0;
    for (int k = 1; k < qau_pkg::SQRT_STAGES; k++) begin
      n_in[k] = n_r[k-1];
      q_in[k] = q_r[k-1];
    end
    for (int k = 0; k < qau_pkg::SQRT_STAGES; k++) begin
      bitc  = qau_pkg::dword_t'(1) << (2 * (qau_pkg::SQRT_STAGES - 1 - k));
      trial = q_in[k] + bitc;
      if (n_in[k] >= trial) begin
        n_nxt[k] = n_in[k] - trial;
        q_nxt[k] = (q_in[k] >> 1) + bitc;
      end else begin
        n_nxt[k] = n_in[k];
        q_nxt[k] = q_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < qau_pkg::SQRT_STAGES; k++) begin
        n_r[k] <= n_nxt[k];
        q_r[k] <= q_nxt[k];
      end
    end
  end

  assign root = q_r[qau_pkg::SQRT_STAGES-1][qau_pkg::DATA_W-1:0];

endmodule

@@ hw/rtl/qau_div.sv @@
// Four-lane pipelined restoring divider with a shared divisor.
// Quotient must fit DIV_STAGES bits. Depends on qau_pkg.
module qau_div (
  input  logic                   clk,
  input  logic                   en,
  input  qau_pkg::dword_t [3:0]  num,
  input  qau_pkg::dword_t        den,
  output qau_pkg::quo_t   [3:0]  quot
);

  localparam int NS = qau_pkg::DIV_STAGES;
  localparam int DW = 2 * qau_pkg::DATA_W;

  // acc holds unconsumed dividend bits on top, quotient bits shift in below
  qau_pkg::dword_t rem_r   [NS][4];
  qau_pkg::quo_t   acc_r   [NS][4];
  qau_pkg::dword_t den_r   [NS];
  qau_pkg::dword_t rem_in  [NS][4];
  qau_pkg::quo_t   acc_in  [NS][4];
  qau_pkg::dword_t den_in  [NS];
  qau_pkg::dword_t rem_nxt [NS][4];
  qau_pkg::quo_t   acc_nxt [NS][4];
  logic [DW:0]     trial;
  logic            qb;

  always_comb begin
    den_in[0] = den;
    for (int l = 0; l < 4; l++) begin
      rem_in[0][l] = num[l] >> NS;
      acc_in[0][l] = num[l][NS-1:0];
    end
    for (int k = 1; k < NS; k++) begin
      den_in[k] = den_r[k-1];
      for (int l = 0; l < 4; l++) begin
        rem_in[k][l] = rem_r[k-1][l];
        acc_in[k][l] = acc_r[k-1][l];
      end
    end
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < 4; l++) begin
        trial = {rem_in[k][l], acc_in[k][l][NS-1]};
        qb    = trial >= {1'b0, den_in[k]};
        rem_nxt[k][l] = qb ? DW'(trial - {1'b0, den_in[k]}) : trial[DW-1:0];
        acc_nxt[k][l] = {acc_in[k][l][NS-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        den_r[k] <= den_in[k];
        for (int l = 0; l < 4; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          acc_r[k][l] <= acc_nxt[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) quot[l] = acc_r[NS-1][l];
  end

endmodule

@@ hw/rtl/qau_back.sv @@
// Back end: product stages, rotation second pass, length root, division
// and result formatting with the output register. Depends on qau_pkg,
// qau_sqrt and qau_div.
module qau_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qau_pkg::entry_t         head,
  input  logic                    empty,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output qau_pkg::quad_t          out_r,
  output logic [1:0]              out_status
);

  localparam int PIPE_N = qau_pkg::SIDE_DEPTH + 4;
  localparam int DW     = qau_pkg::DATA_W;

  typedef struct packed {
    qau_pkg::op_t  op;
    qau_pkg::quad_t a;
    qau_pkg::word_t b0;
    qau_pkg::pmat_t p;
  } s1_t;

  typedef struct packed {
    qau_pkg::op_t   op;
    qau_pkg::quad_t a;
    qau_pkg::word_t b0;
    qau_pkg::quad_t t;
    logic           ov;
    logic [qau_pkg::SQ_W-1:0] s;
  } s2_t;

  typedef struct packed {
    s2_t            base;
    qau_pkg::pmat_t p;
  } s3_t;

  typedef struct packed {
    qau_pkg::op_t   op;
    qau_pkg::quad_t a;
    qau_pkg::quad_t r;
    logic           ov;
    logic [qau_pkg::SQ_W-1:0] s;
  } side_t;

  logic en;
  logic [PIPE_N-1:0] pipe_v_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  s3_t   s3_r, s3_nxt;
  side_t s4_r, s4_nxt;
  side_t sd_r [qau_pkg::SIDE_DEPTH];
  side_t tap, fin;
  qau_pkg::sat_t sv, sv4;
  logic signed [qau_pkg::ACC_W-1:0] s_full;
  logic signed [DW:0] cj [4];
  qau_pkg::word_t m [4];
  qau_pkg::word_t root;
  qau_pkg::dword_t [3:0] num;
  qau_pkg::dword_t den;
  qau_pkg::quo_t [3:0] quot;
  qau_pkg::quad_t res;
  logic fin_ov, neg;
  logic [1:0] fin_st;

  logic           out_valid_r;
  qau_pkg::quad_t out_r_r;
  logic [1:0]     out_status_r;

  // whole pipeline advances unless a finished result is held
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !empty;

  // stage 1: sixteen products
  always_comb begin
    s1_nxt.op = head.op;
    s1_nxt.a  = head.a;
    s1_nxt.b0 = head.b0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        s1_nxt.p[i][j] = $signed(head.a[i]) * $signed(head.y[j]);
  end

  // stage 2: sums, rounding and saturation
  always_comb begin
    s2_nxt.op = s1_r.op;
    s2_nxt.a  = s1_r.a;
    s2_nxt.b0 = s1_r.b0;
    s2_nxt.t  = '0;
    s2_nxt.ov = 1'b0;
    s_full    = qau_pkg::ham_sum(s1_r.p, 2'd0, 4'b0000);
    s2_nxt.s  = s_full[qau_pkg::SQ_W-1:0];
    sv        = '0;
    unique case (s1_r.op)
      qau_pkg::OP_MUL, qau_pkg::OP_ROT: begin
        for (int r = 0; r < 4; r++) begin
          sv = qau_pkg::sat_word(qau_pkg::floor_q(
                 qau_pkg::ham_sum(s1_r.p, 2'(r), qau_pkg::HAM_NEG[r])));
          s2_nxt.t[r] = sv.v;
          s2_nxt.ov   = s2_nxt.ov | sv.ov;
        end
      end
      qau_pkg::OP_DOT: begin
        sv = qau_pkg::sat_word(qau_pkg::floor_q(s_full));
        s2_nxt.t[0] = sv.v;
        s2_nxt.ov   = sv.ov;
      end
      qau_pkg::OP_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          sv = qau_pkg::sat_word(qau_pkg::floor_q(qau_pkg::ext_prod(s1_r.p[r][0])));
          s2_nxt.t[r] = sv.v;
          s2_nxt.ov   = s2_nxt.ov | sv.ov;
        end
      end
      qau_pkg::OP_CONJ: begin
        s2_nxt.t[0] = s1_r.a[0];
        for (int r = 1; r < 4; r++) begin
          sv = qau_pkg::sat_word(-qau_pkg::ext_word(s1_r.a[r]));
          s2_nxt.t[r] = sv.v;
          s2_nxt.ov   = s2_nxt.ov | sv.ov;
        end
      end
      default: begin
      end
    endcase
  end

  // stage 3: rotation second pass, t * conj(a) with an exact conjugate
  always_comb begin
    cj[0] = $signed({s2_r.a[0][DW-1], s2_r.a[0]});
    for (int j = 1; j < 4; j++) cj[j] = -$signed({s2_r.a[j][DW-1], s2_r.a[j]});
    s3_nxt.base = s2_r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        s3_nxt.p[i][j] = $signed(s2_r.t[i]) * cj[j];
  end

  // stage 4
  always_comb begin
    s4_nxt.op = s3_r.base.op;
    s4_nxt.a  = s3_r.base.a;
    s4_nxt.s  = s3_r.base.s;
    s4_nxt.r  = s3_r.base.t;
    s4_nxt.ov = s3_r.base.ov;
    sv4       = '0;
    if (s3_r.base.op == qau_pkg::OP_ROT) begin
      for (int r = 0; r < 4; r++) begin
        sv4 = qau_pkg::sat_word(qau_pkg::floor_q(
                qau_pkg::ham_sum(s3_r.p, 2'(r), qau_pkg::HAM_NEG[r])));
        s4_nxt.r[r] = sv4.v;
        s4_nxt.ov   = s4_nxt.ov | sv4.ov;
      end
      s4_nxt.r[0] = s3_r.base.b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      sd_r[0] <= s4_r;
      for (int k = 1; k < qau_pkg::SIDE_DEPTH; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pipe_v_r    <= {pipe_v_r[PIPE_N-2:0], !empty};
      out_valid_r <= pipe_v_r[PIPE_N-1];
    end
  end

  qau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .s_in (s4_r.s[2*DW-1:0]),
    .root (root)
  );

  // divider operands, aligned with the root
  always_comb begin
    tap = sd_r[qau_pkg::SQRT_STAGES-1];
    num = '0;
    den = '0;
    for (int i = 0; i < 4; i++) m[i] = tap.a[i][DW-1] ? -tap.a[i] : tap.a[i];
    unique case (tap.op)
      qau_pkg::OP_NORM: begin
        for (int i = 0; i < 4; i++) num[i] = qau_pkg::dword_t'(m[i]) << qau_pkg::FRAC_W;
        den = tap.s[2*DW] ? qau_pkg::dword_t'(1) << DW : qau_pkg::dword_t'(root);
      end
      qau_pkg::OP_INV: begin
        for (int i = 0; i < 4; i++) num[i] = {m[i], qau_pkg::word_t'(0)};
        den = tap.s[2*DW-1:0];
      end
      default: begin
      end
    endcase
  end

  qau_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (num),
    .den  (den),
    .quot (quot)
  );

  // result formatting
  always_comb begin
    fin    = sd_r[qau_pkg::SIDE_DEPTH-1];
    res    = fin.r;
    fin_ov = fin.ov;
    fin_st = qau_pkg::ST_OK;
    neg    = 1'b0;
    unique case (fin.op)
      qau_pkg::OP_NORM: begin
        if (fin.s == '0) begin
          res    = '0;
          res[0] = qau_pkg::ONE_Q;
        end else begin
          for (int i = 0; i < 4; i++)
            res[i] = fin.a[i][DW-1] ? -quot[i][DW-1:0] : quot[i][DW-1:0];
        end
      end
      qau_pkg::OP_INV: begin
        res    = '0;
        fin_ov = 1'b0;
        if (fin.s[2*DW]) begin
          // all four at the most negative value: every quotient truncates to zero
        end else if (fin.s == '0) begin
          fin_st = qau_pkg::ST_ZERO_INV;
        end else begin
          for (int i = 0; i < 4; i++) begin
            neg = fin.a[i][DW-1] ^ (i != 0);
            if (fin.a[i] == '0) begin
              res[i] = '0;
            end else if (!neg) begin
              if (quot[i] > qau_pkg::quo_t'(qau_pkg::WORD_MAX)) begin
                res[i] = qau_pkg::WORD_MAX;
                fin_ov = 1'b1;
              end else begin
                res[i] = quot[i][DW-1:0];
              end
            end else begin
              if (quot[i] > (qau_pkg::quo_t'(1) << (DW - 1))) begin
                res[i] = qau_pkg::WORD_MIN;
                fin_ov = 1'b1;
              end else begin
                res[i] = -quot[i][DW-1:0];
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (fin_st == qau_pkg::ST_OK && fin_ov) fin_st = qau_pkg::ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r_r      <= res;
      out_status_r <= fin_st;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_r      = out_r_r;
  assign out_status = out_status_r;

endmodule

@@ hw/rtl/quaternion_arithmetic_unit_core.sv @@
// Quaternion arithmetic unit, top level.
// Depends on qau_pkg, qau_front, qau_fifo and qau_back.
//
// Usage:
//  - Input channel (in_*): command plus quaternions a and b, signed Q16.16.
//    A transaction completes on a clock edge with in_valid high and
//    in_stall low. Commands: multiply, scale, conjugate, dot, rotate,
//    normalize, inverse; code 7 returns zeros.
//  - Result channel (out_*): r_w..r_z and status, one transaction per input,
//    in input order. Taken on an edge with out_valid high, out_stall low.
//  - Path from input transaction to out_valid: the queue, the 4 product/sum
//    stages, the 32-stage square root, the 33-stage divider and the output
//    register, which every transaction passes through.
//  - Throughput: one transaction per cycle, sustained while out_stall does not hold a waiting result.
//  - A 4-entry queue parts the front end from the datapath. in_stall is
//    high only while that queue is full.
//  - out_stall with a result waiting freezes the whole datapath; the queue
//    keeps accepting until it is full.
//  - Reset (rst_n low, synchronous) empties the queue and clears all
//    valid bits; no result is presented until new input arrives.
module quaternion_arithmetic_unit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_command,
  input  logic signed [31:0]   in_a_w,
  input  logic signed [31:0]   in_a_x,
  input  logic signed [31:0]   in_a_y,
  input  logic signed [31:0]   in_a_z,
  input  logic signed [31:0]   in_b_w,
  input  logic signed [31:0]   in_b_x,
  input  logic signed [31:0]   in_b_y,
  input  logic signed [31:0]   in_b_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_r_w,
  output logic signed [31:0]   out_r_x,
  output logic signed [31:0]   out_r_y,
  output logic signed [31:0]   out_r_z,
  output logic [1:0]           out_status
);

  qau_pkg::entry_t entry, head;
  logic push, pop, full, empty;
  qau_pkg::quad_t r;

  // front end: decode and operand select
  qau_front u_front (
    .in_valid   (in_valid),
    .fifo_full  (full),
    .in_command (in_command),
    .in_a_w     (in_a_w),
    .in_a_x     (in_a_x),
    .in_a_y     (in_a_y),
    .in_a_z     (in_a_z),
    .in_b_w     (in_b_w),
    .in_b_x     (in_b_x),
    .in_b_y     (in_b_y),
    .in_b_z     (in_b_z),
    .in_stall   (in_stall),
    .push       (push),
    .entry      (entry)
  );

  qau_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // back end: arithmetic pipeline and output register
  qau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_r      (r),
    .out_status (out_status)
  );

  assign out_r_w = r[0];
  assign out_r_x = r[1];
  assign out_r_y = r[2];
  assign out_r_z = r[3];

endmodule
